@@ rtl/edf_pkg.sv @@
// Shared types and constants for the EDF periodic task scheduler.
// Depends on nothing; every other file in rtl/ except edf_slot_mem refers to it by scoped names.
package edf_pkg;

  localparam int DEF_MAX_TASKS   = 8;
  localparam int DEF_VALUE_WIDTH = 16;

  localparam int CMD_W         = 2;
  localparam int SLOT_FIELD_W  = 3;
  localparam int VALUE_FIELD_W = 16;
  localparam int TIME_W        = 32;
  localparam int ABS_W         = 33;
  localparam int TASK_COUNT_W  = 4;
  localparam int CFG_INDEX_W   = 2;
  localparam int CFG_DATA_W    = 32;

  localparam logic [CMD_W-1:0] CMD_LOAD    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_TICK    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

  localparam logic [CFG_INDEX_W-1:0] CFG_TASK_COUNT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SCHED_LEN  = 2'd1;

  // Per-slot context handed from the sequencer to the shared slot unit.
  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic              active;
    logic [ABS_W-1:0]  best;
  } scan_ctl_t;

endpackage

@@ rtl/edf_slot_mem.sv @@
// Slot record memory: one write port, one registered read port.
// Entries never written read as RST_WORD through per-entry valid bits. Uses no package.
module edf_slot_mem #(
  parameter int               WIDTH    = 8,
  parameter int               DEPTH    = 8,
  parameter int               AW       = 3,
  parameter logic [WIDTH-1:0] RST_WORD = '0
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [DEPTH-1:0] valid_r;
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= valid_r[raddr] ? mem_r[raddr] : RST_WORD;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (we) begin
      valid_r[waddr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/edf_slot_unit.sv @@
// Shared per-slot update unit: release, deadline compare and phase advance.
// Depends on edf_pkg for widths and the scan context struct.
module edf_slot_unit #(
  parameter int VALUE_WIDTH = edf_pkg::DEF_VALUE_WIDTH
) (
  input  edf_pkg::scan_ctl_t           ctl,
  input  logic [VALUE_WIDTH-1:0]       burst,
  input  logic [VALUE_WIDTH-1:0]       deadline,
  input  logic [VALUE_WIDTH-1:0]       period,
  input  logic [VALUE_WIDTH-1:0]       remaining,
  input  logic [edf_pkg::ABS_W-1:0]    abs_deadline,
  input  logic [VALUE_WIDTH-1:0]       phase,
  output logic [VALUE_WIDTH-1:0]       remaining_nxt,
  output logic [edf_pkg::ABS_W-1:0]    abs_deadline_nxt,
  output logic [VALUE_WIDTH-1:0]       phase_nxt,
  output logic                         take
);

  logic             release_now;
  logic [VALUE_WIDTH:0] phase_inc;

  // A slot is released at every nonzero tick where its phase is back at zero.
  assign release_now = (ctl.now != '0) && (phase == '0);

  assign abs_deadline_nxt = release_now
    ? ({1'b0, ctl.now} + edf_pkg::ABS_W'(deadline)) : abs_deadline;
  assign remaining_nxt = release_now ? burst : remaining;

  assign take = ctl.active && (remaining_nxt != '0) && (abs_deadline_nxt < ctl.best);

  assign phase_inc = {1'b0, phase} + (VALUE_WIDTH+1)'(1);
  assign phase_nxt = (phase_inc >= {1'b0, period}) ? '0 : phase_inc[VALUE_WIDTH-1:0];

endmodule

@@ rtl/edf_periodic_task_scheduler.sv @@
// Top level of the EDF periodic task scheduler: command sequencer and result register.
// Depends on edf_pkg, edf_slot_mem and edf_slot_unit.

// The scheduler takes one command beat at a time and returns exactly one result beat
// for each. All per-slot state lives in a record memory with one write and one read
// port that a small sequencer walks one slot per cycle through one shared update unit.
// A tick steps through acceptance, a scan state per slot for release, compare and
// write-back, a commit state for the winning slot's decrement, and an output state
// that hands the result to the output register. A restart sweeps every slot in a
// restart state before the output state, a load writes its slot in a load state, and a tick at
// or past the schedule length, an unused command or a load to a slot number of MAX_TASKS
// or more goes straight to the output state. The input is not ready while a command is
// in work; a finished result waits in the output register while the next command is
// accepted. Slots that were never loaded read as burst 0, deadline 0, period 1. The
// configuration port is always ready and must only be written while the block is idle.
module edf_periodic_task_scheduler #(
  parameter int MAX_TASKS   = edf_pkg::DEF_MAX_TASKS,
  parameter int VALUE_WIDTH = edf_pkg::DEF_VALUE_WIDTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Command channel.
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [edf_pkg::CMD_W-1:0]          in_command,
  input  logic [edf_pkg::SLOT_FIELD_W-1:0]   in_task_slot,
  input  logic [edf_pkg::VALUE_FIELD_W-1:0]  in_burst,
  input  logic [edf_pkg::VALUE_FIELD_W-1:0]  in_relative_deadline,
  input  logic [edf_pkg::VALUE_FIELD_W-1:0]  in_period,
  // Result channel.
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [edf_pkg::TIME_W-1:0]         out_tick_time,
  output logic                               out_task_ran,
  output logic [edf_pkg::SLOT_FIELD_W-1:0]   out_running_task,
  output logic                               out_idle_start,
  output logic                               out_done_res,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [edf_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [edf_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int EXT_W  = (SLOT_W > edf_pkg::SLOT_FIELD_W) ? SLOT_W : edf_pkg::SLOT_FIELD_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);

  // One memory word holds everything the scheduler knows about a slot.
  typedef struct packed {
    logic [VALUE_WIDTH-1:0]    burst;
    logic [VALUE_WIDTH-1:0]    deadline;
    logic [VALUE_WIDTH-1:0]    period;
    logic [VALUE_WIDTH-1:0]    remaining;
    logic [edf_pkg::ABS_W-1:0] abs_deadline;
    logic [VALUE_WIDTH-1:0]    phase;
  } slot_rec_t;

  localparam slot_rec_t REC_RST = '{
    burst:        '0,
    deadline:     '0,
    period:       VALUE_WIDTH'(1),
    remaining:    '0,
    abs_deadline: '0,
    phase:        '0
  };

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_RESTART,
    S_LOAD,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [edf_pkg::TASK_COUNT_W-1:0] task_count_r;
  logic [edf_pkg::TIME_W-1:0]       sched_len_r;

  // Schedule state outside the slot memory.
  logic [edf_pkg::TIME_W-1:0] time_r;
  logic                       idle_r;

  // Sequencer working registers.
  logic [SLOT_W-1:0]         idx_r;
  logic [edf_pkg::ABS_W-1:0] best_r;
  logic                      found_r;
  logic [SLOT_W-1:0]         chosen_r;
  slot_rec_t                 chosen_rec_r;
  logic [SLOT_W-1:0]         ld_slot_r;
  logic [VALUE_WIDTH-1:0]    ld_burst_r;
  logic [VALUE_WIDTH-1:0]    ld_deadline_r;
  logic [VALUE_WIDTH-1:0]    ld_period_r;

  // Result waiting for the output register, and the output register itself.
  logic [edf_pkg::TIME_W-1:0]       res_time_r;
  logic                             res_ran_r;
  logic [edf_pkg::SLOT_FIELD_W-1:0] res_task_r;
  logic                             res_idle_r;
  logic                             res_done_r;
  logic                             out_valid_r;
  logic [edf_pkg::TIME_W-1:0]       out_time_r;
  logic                             out_ran_r;
  logic [edf_pkg::SLOT_FIELD_W-1:0] out_task_r;
  logic                             out_idle_r;
  logic                             out_done_r;

  // Memory ports.
  logic              mem_we;
  logic [SLOT_W-1:0] mem_waddr;
  slot_rec_t         mem_wdata;
  logic [SLOT_W-1:0] mem_raddr;
  slot_rec_t         mem_rdata;

  // Shared unit.
  edf_pkg::scan_ctl_t        scan_ctl;
  logic [VALUE_WIDTH-1:0]    unit_remaining;
  logic [edf_pkg::ABS_W-1:0] unit_abs_deadline;
  logic [VALUE_WIDTH-1:0]    unit_phase;
  logic                      unit_take;
  slot_rec_t                 scan_rec;
  slot_rec_t                 commit_rec;

  logic              in_fire;
  logic              load_in_range;
  logic [SLOT_W-1:0] in_slot_addr;
  logic              last_slot;
  logic [SLOT_W-1:0] next_idx;
  logic [EXT_W-1:0]  chosen_ext;

  assign in_ready  = (state_r == S_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  assign load_in_range = (32'(in_task_slot) < MAX_TASKS);
  assign in_slot_addr  = SLOT_W'(in_task_slot);
  assign last_slot     = (idx_r == LAST_SLOT);
  assign next_idx      = last_slot ? '0 : idx_r + SLOT_W'(1);
  assign chosen_ext    = EXT_W'(chosen_r);

  assign scan_ctl.now    = time_r;
  assign scan_ctl.active = (32'(idx_r) < 32'(task_count_r));
  assign scan_ctl.best   = best_r;

  edf_slot_unit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_unit (
    .ctl              (scan_ctl),
    .burst            (mem_rdata.burst),
    .deadline         (mem_rdata.deadline),
    .period           (mem_rdata.period),
    .remaining        (mem_rdata.remaining),
    .abs_deadline     (mem_rdata.abs_deadline),
    .phase            (mem_rdata.phase),
    .remaining_nxt    (unit_remaining),
    .abs_deadline_nxt (unit_abs_deadline),
    .phase_nxt        (unit_phase),
    .take             (unit_take)
  );

  always_comb begin
    scan_rec              = mem_rdata;
    scan_rec.remaining    = unit_remaining;
    scan_rec.abs_deadline = unit_abs_deadline;
    scan_rec.phase        = unit_phase;
    commit_rec            = chosen_rec_r;
    commit_rec.remaining  = chosen_rec_r.remaining - VALUE_WIDTH'(1);
  end

  // Memory port steering. In scan and restart, reads run one slot ahead of the slot being written.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = idx_r;
    mem_wdata = scan_rec;
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        mem_raddr = (in_command == edf_pkg::CMD_LOAD) ? in_slot_addr : '0;
      end
      S_SCAN: begin
        mem_we    = 1'b1;
        mem_raddr = next_idx;
      end
      S_RESTART: begin
        mem_we                 = 1'b1;
        mem_raddr              = next_idx;
        mem_wdata              = mem_rdata;
        mem_wdata.remaining    = mem_rdata.burst;
        mem_wdata.abs_deadline = edf_pkg::ABS_W'(mem_rdata.deadline);
        mem_wdata.phase        = '0;
      end
      S_COMMIT: begin
        mem_we    = found_r;
        mem_waddr = chosen_r;
        mem_wdata = commit_rec;
      end
      S_LOAD: begin
        mem_we                 = 1'b1;
        mem_waddr              = ld_slot_r;
        mem_wdata.burst        = ld_burst_r;
        mem_wdata.deadline     = ld_deadline_r;
        mem_wdata.period       = ld_period_r;
        mem_wdata.remaining    = ld_burst_r;
        mem_wdata.abs_deadline = edf_pkg::ABS_W'(ld_deadline_r);
        mem_wdata.phase        = mem_rdata.phase;
      end
      S_OUT: begin
        mem_we = 1'b0;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  edf_slot_mem #(
    .WIDTH    ($bits(slot_rec_t)),
    .DEPTH    (MAX_TASKS),
    .AW       (SLOT_W),
    .RST_WORD (REC_RST)
  ) u_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer, schedule state and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      task_count_r <= edf_pkg::TASK_COUNT_W'(1);
      sched_len_r  <= edf_pkg::TIME_W'(1);
      time_r       <= '0;
      idle_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          edf_pkg::CFG_TASK_COUNT: task_count_r <= cfg_data[edf_pkg::TASK_COUNT_W-1:0];
          edf_pkg::CFG_SCHED_LEN:  sched_len_r  <= cfg_data[edf_pkg::TIME_W-1:0];
          default: begin
          end
        endcase
      end

      // In the output state a taken beat is replaced by the next result instead.
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            // Every command other than a tick reports all zeros. A tick at or past the
            // schedule length reports done and leaves the schedule state and slot memory alone.
            res_time_r    <= (in_command == edf_pkg::CMD_TICK) ? time_r : '0;
            res_ran_r     <= 1'b0;
            res_task_r    <= '0;
            res_idle_r    <= 1'b0;
            res_done_r    <= (in_command == edf_pkg::CMD_TICK) && (time_r >= sched_len_r);
            idx_r         <= '0;
            found_r       <= 1'b0;
            chosen_r      <= '0;
            best_r        <= edf_pkg::ABS_W'(sched_len_r) + edf_pkg::ABS_W'(1);
            ld_slot_r     <= in_slot_addr;
            ld_burst_r    <= VALUE_WIDTH'(in_burst);
            ld_deadline_r <= VALUE_WIDTH'(in_relative_deadline);
            ld_period_r   <= VALUE_WIDTH'(in_period);
            priority if (in_command == edf_pkg::CMD_TICK) begin
              if (time_r >= sched_len_r) begin
                state_r <= S_OUT;
              end else begin
                state_r <= S_SCAN;
              end
            end else if (in_command == edf_pkg::CMD_RESTART) begin
              state_r <= S_RESTART;
            end else if ((in_command == edf_pkg::CMD_LOAD) && load_in_range) begin
              state_r <= S_LOAD;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_SCAN: begin
          // Strict less-than keeps the lowest slot on equal deadlines.
          if (unit_take) begin
            best_r       <= unit_abs_deadline;
            found_r      <= 1'b1;
            chosen_r     <= idx_r;
            chosen_rec_r <= scan_rec;
          end
          idx_r <= next_idx;
          if (last_slot) begin
            state_r <= S_COMMIT;
          end
        end
        S_COMMIT: begin
          if (found_r) begin
            res_ran_r  <= 1'b1;
            res_task_r <= chosen_ext[edf_pkg::SLOT_FIELD_W-1:0];
            idle_r     <= 1'b0;
          end else begin
            // Only the first idle tick of a stretch raises idle_start.
            res_idle_r <= !idle_r;
            idle_r     <= 1'b1;
          end
          time_r  <= time_r + edf_pkg::TIME_W'(1);
          state_r <= S_OUT;
        end
        S_RESTART: begin
          idx_r <= next_idx;
          if (last_slot) begin
            time_r  <= '0;
            idle_r  <= 1'b0;
            state_r <= S_OUT;
          end
        end
        S_LOAD: begin
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_time_r  <= res_time_r;
            out_ran_r   <= res_ran_r;
            out_task_r  <= res_task_r;
            out_idle_r  <= res_idle_r;
            out_done_r  <= res_done_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tick_time    = out_time_r;
  assign out_task_ran     = out_ran_r;
  assign out_running_task = out_task_r;
  assign out_idle_start   = out_idle_r;
  assign out_done_res     = out_done_r;

endmodule

@@ rtl/edf_checker.sv @@
// Port-level assertions for the EDF periodic task scheduler, bound to the top level.
// Depends on edf_pkg for field widths.
module edf_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [edf_pkg::TIME_W-1:0]       out_tick_time,
  input logic                             out_task_ran,
  input logic [edf_pkg::SLOT_FIELD_W-1:0] out_running_task,
  input logic                             out_idle_start,
  input logic                             out_done_res
);

  // A done beat carries nothing but the time and the done flag.
  a_done_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |-> (!out_task_ran && !out_idle_start
                                     && (out_running_task == '0)))
    else $error("done beat carries scheduling fields");

  // No slot number is reported on a beat where no task ran.
  a_no_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_task_ran) |-> (out_running_task == '0))
    else $error("running_task nonzero without a task");

  // A tick either ran a task or started an idle stretch, never both.
  a_ran_or_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_task_ran && out_idle_start))
    else $error("task_ran and idle_start together");

  // The block works on one command at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready right after an accepted beat");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_tick_time)))
    else $error("stalled result beat changed");

endmodule

bind edf_periodic_task_scheduler edf_checker u_edf_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_tick_time    (out_tick_time),
  .out_task_ran     (out_task_ran),
  .out_running_task (out_running_task),
  .out_idle_start   (out_idle_start),
  .out_done_res     (out_done_res)
);
